/* hw/rtl/bba_pkg.sv */
package bba_pkg;

  // build-time defaults
  localparam int MAX_LEVELS_DEF = 10;
  localparam int PAGE_BITS      = 40;

  // field widths
  localparam int PAGE_W    = 40;
  localparam int ORDER_W   = 4;
  localparam int DEPTH_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_DEPTH  = 1'd1;
  localparam logic [DEPTH_W-1:0]   DEPTH_RESET     = 4'd10;

  // item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_BLOCK     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE = 2'd2;

  // node marks
  typedef enum logic [1:0] {
    MARK_FREE  = 2'd0,
    MARK_USED  = 2'd1,
    MARK_SPLIT = 2'd2
  } mark_t;

  // granted page numbers wrap at the page number width
  localparam int PAGE_KEEP = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam logic [PAGE_W:0] PAGE_ONE_EXT = 1;
  localparam logic [PAGE_W-1:0] PAGE_MASK =
    PAGE_W'((PAGE_ONE_EXT << PAGE_KEEP) - PAGE_ONE_EXT);

  typedef struct packed {
    logic               kind;
    logic [ORDER_W-1:0] block_order;
    logic [PAGE_W-1:0]  page_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   block_page;
  } out_item_t;

endpackage

/* hw/rtl/buddy_block_allocator.sv */
// Sequence: a taken word is checked, then each tree node visited is read and evaluated; a free
//   then releases the deepest marked node and reads each buddy while merging up toward the root.
// Flow: one word at a time; a new word is taken only once the result of the last one has been
//   placed in the output register; range and order faults skip the tree walk.
// Reset: synchronous active low; the mark memory is then cleared one node per cycle,
//   all 2^(MAX_D+1)-1 nodes, with the input not ready; configuration writes are taken throughout.
module buddy_block_allocator #(
  parameter int MAX_LEVELS = bba_pkg::MAX_LEVELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bba_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bba_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bba_pkg::PAGE_W-1:0]          cfg_data
);

  localparam int PW        = bba_pkg::PAGE_W;
  localparam int DEPTH_CAP = (1 << bba_pkg::DEPTH_W) - 1;
  localparam int MAX_D     = (MAX_LEVELS < DEPTH_CAP) ? MAX_LEVELS : DEPTH_CAP;
  localparam int LVL_W     = $clog2(MAX_D + 1);
  localparam int IDX_W     = MAX_D + 1;
  localparam int NODE_COUNT = (2 << MAX_D) - 1;
  localparam logic [bba_pkg::DEPTH_W-1:0] MAX_D_V = bba_pkg::DEPTH_W'(MAX_D);

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_CHECK    = 9'b000000100,
    ST_READ     = 9'b000001000,
    ST_EVAL     = 9'b000010000,
    ST_RELEASE  = 9'b000100000,
    ST_BUDDY_RD = 9'b001000000,
    ST_BUDDY_EV = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                clr_idx_r, clr_idx_nxt;
  logic                            kind_r, kind_nxt;
  logic [bba_pkg::ORDER_W-1:0]     order_r, order_nxt;
  logic [PW-1:0]                   addr_r, addr_nxt;
  logic [LVL_W-1:0]                tgt_r, tgt_nxt;
  logic [LVL_W-1:0]                d_r, d_nxt;
  logic [MAX_D-1:0]                n_r, n_nxt;
  logic [MAX_D-1:0]                pend_r, pend_nxt;
  logic [MAX_D-1:0]                offset_r, offset_nxt;
  logic [LVL_W-1:0]                last_d_r, last_d_nxt;
  logic [MAX_D-1:0]                last_n_r, last_n_nxt;
  logic [bba_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bba_pkg::out_item_t              out_data_r, out_data_nxt;
  logic [PW-1:0]                   base_r, base_nxt;
  logic [bba_pkg::DEPTH_W-1:0]     depth_r, depth_nxt;

  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [1:0]                      ram_wdata;
  logic                            ram_re;
  logic [IDX_W-1:0]                ram_raddr;
  logic [1:0]                      ram_rdata;

  logic [LVL_W-1:0]                td_eff;
  logic [IDX_W-1:0]                cur_idx;
  logic [IDX_W-1:0]                buddy_idx;
  logic [PW:0]                     range_diff;
  logic [PW-1:0]                   range_hi;
  logic                            outside;
  logic [LVL_W-1:0]                pop_lvl;
  logic [MAX_D-1:0]                pop_n;
  logic [LVL_W-1:0]                bit_sel;
  logic [MAX_D-1:0]                offset_sh;
  logic [PW-1:0]                   grant_page;
  logic                            at_tgt;

  // level-order index: 2^d - 1 + n
  function automatic logic [IDX_W-1:0] node_idx(input logic [LVL_W-1:0] d,
                                                input logic [MAX_D-1:0] n);
    logic [IDX_W-1:0] lvl_bit;
    lvl_bit  = IDX_W'(1) << d;
    node_idx = (lvl_bit | IDX_W'(n)) - IDX_W'(1);
  endfunction

  // mark memory
  bba_ram #(
    .WIDTH (2),
    .DEPTH (NODE_COUNT)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective tree depth and node addressing
  assign td_eff    = LVL_W'((depth_r > MAX_D_V) ? MAX_D_V : depth_r);
  assign cur_idx   = node_idx(d_r, n_r);
  assign buddy_idx = node_idx(d_r, n_r ^ MAX_D'(1));
  assign at_tgt    = (d_r == tgt_r);

  // region check for a free word
  assign range_diff = {1'b0, addr_r} - {1'b0, base_r};
  assign range_hi   = range_diff[PW-1:0] & ~((PW'(1) << td_eff) - PW'(1));
  assign outside    = range_diff[PW] | (|range_hi);

  // deepest pending right-child retry
  always_comb begin
    pop_lvl = '0;
    for (int i = 0; i < MAX_D; i++) begin
      if (pend_r[i]) begin
        pop_lvl = LVL_W'(i);
      end
    end
  end
  assign pop_n = (n_r >> (d_r - pop_lvl - LVL_W'(1))) | MAX_D'(1);

  // next address bit on the free walk
  assign bit_sel   = td_eff - d_r - LVL_W'(1);
  assign offset_sh = offset_r >> bit_sel;

  // granted page number
  assign grant_page = (base_r + (PW'(n_r) << order_r)) & bba_pkg::PAGE_MASK;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    kind_nxt      = kind_r;
    order_nxt     = order_r;
    addr_nxt      = addr_r;
    tgt_nxt       = tgt_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    offset_nxt    = offset_r;
    last_d_nxt    = last_d_r;
    last_n_nxt    = last_n_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    base_nxt      = base_r;
    depth_nxt     = depth_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_idx;
    ram_wdata     = bba_pkg::MARK_FREE;
    ram_re        = 1'b0;
    ram_raddr     = cur_idx;

    // configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        bba_pkg::CFG_REGION_BASE: base_nxt  = cfg_data;
        bba_pkg::CFG_TREE_DEPTH:  depth_nxt = cfg_data[bba_pkg::DEPTH_W-1:0];
      endcase
    end

    // result word taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          order_nxt = in_data.block_order;
          addr_nxt  = in_data.page_address;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        d_nxt      = '0;
        n_nxt      = '0;
        pend_nxt   = '0;
        last_d_nxt = '0;
        last_n_nxt = '0;
        status_nxt = bba_pkg::STAT_DONE;
        if (kind_r == bba_pkg::KIND_ALLOC) begin
          if (order_r > bba_pkg::ORDER_W'(td_eff)) begin
            status_nxt = bba_pkg::STAT_NO_BLOCK;
            state_nxt  = ST_FINISH;
          end else begin
            tgt_nxt   = td_eff - LVL_W'(order_r);
            state_nxt = ST_READ;
          end
        end else begin
          offset_nxt = range_diff[MAX_D-1:0];
          if (outside) begin
            status_nxt = bba_pkg::STAT_OUT_OF_RANGE;
            state_nxt  = ST_FINISH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        if (kind_r == bba_pkg::KIND_ALLOC) begin
          // depth-first search step
          priority if (ram_rdata == bba_pkg::MARK_USED ||
                       (ram_rdata == bba_pkg::MARK_SPLIT && at_tgt)) begin
            if (d_r == '0 || n_r[0]) begin
              state_nxt = ST_FINISH;
              if (pend_r == '0) begin
                status_nxt = bba_pkg::STAT_NO_BLOCK;
              end else begin
                for (int i = 0; i < MAX_D; i++) begin
                  if (LVL_W'(i) == pop_lvl) pend_nxt[i] = 1'b0;
                end
                d_nxt     = pop_lvl + LVL_W'(1);
                n_nxt     = pop_n;
                state_nxt = ST_READ;
              end
            end else begin
              n_nxt     = n_r + MAX_D'(1);
              state_nxt = ST_READ;
            end
          end else if (ram_rdata == bba_pkg::MARK_SPLIT) begin
            for (int i = 0; i < MAX_D; i++) begin
              if (LVL_W'(i) == d_r) pend_nxt[i] = 1'b1;
            end
            d_nxt     = d_r + LVL_W'(1);
            n_nxt     = n_r << 1;
            state_nxt = ST_READ;
          end else if (ram_rdata == bba_pkg::MARK_FREE) begin
            ram_we = 1'b1;
            if (at_tgt) begin
              ram_wdata = bba_pkg::MARK_USED;
              state_nxt = ST_FINISH;
            end else begin
              ram_wdata = bba_pkg::MARK_SPLIT;
              d_nxt     = d_r + LVL_W'(1);
              n_nxt     = n_r << 1;
              state_nxt = ST_READ;
            end
          end else begin
            // unknown mark fails like a used node at a dead end
            state_nxt = ST_FINISH;
            if (pend_r == '0) begin
              status_nxt = bba_pkg::STAT_NO_BLOCK;
            end else begin
              for (int i = 0; i < MAX_D; i++) begin
                if (LVL_W'(i) == pop_lvl) pend_nxt[i] = 1'b0;
              end
              d_nxt     = pop_lvl + LVL_W'(1);
              n_nxt     = pop_n;
              state_nxt = ST_READ;
            end
          end
        end else begin
          // free walk toward the deepest marked node
          if (ram_rdata != bba_pkg::MARK_FREE) begin
            last_d_nxt = d_r;
            last_n_nxt = n_r;
            if (d_r == td_eff) begin
              state_nxt = ST_RELEASE;
            end else begin
              d_nxt     = d_r + LVL_W'(1);
              n_nxt     = (n_r << 1) | MAX_D'(offset_sh[0]);
              state_nxt = ST_READ;
            end
          end else begin
            d_nxt     = last_d_r;
            n_nxt     = last_n_r;
            state_nxt = ST_RELEASE;
          end
        end
      end

      ST_RELEASE: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::MARK_FREE;
        state_nxt = (d_r == '0) ? ST_FINISH : ST_BUDDY_RD;
      end

      ST_BUDDY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = buddy_idx;
        state_nxt = ST_BUDDY_EV;
      end

      ST_BUDDY_EV: begin
        // merge upward while the buddy is free
        if (ram_rdata == bba_pkg::MARK_FREE) begin
          d_nxt     = d_r - LVL_W'(1);
          n_nxt     = n_r >> 1;
          state_nxt = ST_RELEASE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.block_page =
            (kind_r == bba_pkg::KIND_ALLOC && status_r == bba_pkg::STAT_DONE) ?
            grant_page : '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      depth_r     <= bba_pkg::DEPTH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      depth_r     <= depth_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    order_r    <= order_nxt;
    addr_r     <= addr_nxt;
    tgt_r      <= tgt_nxt;
    d_r        <= d_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    offset_r   <= offset_nxt;
    last_d_r   <= last_d_nxt;
    last_n_r   <= last_n_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // pending retries only sit above the node being searched
  a_pend_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && kind_r == bba_pkg::KIND_ALLOC) |-> ((pend_r >> d_r) == '0))
    else $error("pending retry at or below current level");

  // the walk never goes below the target or leaf level
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |->
      (d_r <= td_eff && (kind_r == bba_pkg::KIND_FREE || d_r <= tgt_r)))
    else $error("node level past its bound");

  // an allocate never reports an address range fault
  a_alloc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && kind_r == bba_pkg::KIND_ALLOC) |->
      (status_r != bba_pkg::STAT_OUT_OF_RANGE))
    else $error("range fault on allocate");

  // releasing the root ends the merge
  a_root_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELEASE && d_r == '0) |=> (state_r == ST_FINISH))
    else $error("merge continued past the root");

endmodule

/* hw/rtl/bba_ram.sv */
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* test/tb_buddy_block_allocator.sv */
// shadow copy of the allocator tree, with the replies it is owed
class allocator_shadow;
  bba_pkg::mark_t                     tree [(2 << bba_pkg::MAX_LEVELS_DEF) - 1];
  logic [bba_pkg::PAGE_W-1:0]         base_page;
  logic [bba_pkg::DEPTH_W-1:0]        depth_reg;
  bba_pkg::out_item_t                 due_replies [$];
  logic [bba_pkg::PAGE_W-1:0]         live_page [$];
  logic [bba_pkg::ORDER_W-1:0]        live_order [$];
  int mismatches;
  int replies_seen;
  int grants;
  int refusals;
  int releases;
  int rejects;

  function new();
    foreach (tree[i]) tree[i] = bba_pkg::MARK_FREE;
    base_page    = '0;
    depth_reg    = bba_pkg::DEPTH_RESET;
    mismatches   = 0;
    replies_seen = 0;
    grants       = 0;
    refusals     = 0;
    releases     = 0;
    rejects      = 0;
  endfunction

  // depth register saturates at the tree size
  function int unsigned levels();
    return (depth_reg > bba_pkg::MAX_LEVELS_DEF) ? bba_pkg::MAX_LEVELS_DEF : int'(depth_reg);
  endfunction

  // level-order position of node idx on level lvl
  function int unsigned slot(int unsigned lvl, int unsigned idx);
    int unsigned s;
    if (lvl == 0) return 0;
    s = (1 << lvl) - 1 + (idx & ((1 << lvl) - 1));
    return (s < $size(tree)) ? s : 0;
  endfunction

  function int pending();
    return due_replies.size();
  endfunction

  function void set_register(logic [bba_pkg::CFG_IDX_W-1:0] idx,
                             logic [bba_pkg::PAGE_W-1:0] value);
    if (idx == bba_pkg::CFG_REGION_BASE) base_page = value;
    else depth_reg = value[bba_pkg::DEPTH_W-1:0];
    live_page.delete();
    live_order.delete();
  endfunction

  // leftmost free node on level tgt, depth first, left child first;
  // the stack holds split nodes whose right child is still to be tried
  function bit find_block(int unsigned tgt, output int unsigned hit);
    int unsigned up_lvl [0:15];
    int unsigned up_idx [0:15];
    int unsigned sp;
    int unsigned lvl;
    int unsigned idx;
    bba_pkg::mark_t m;
    sp  = 0;
    lvl = 0;
    idx = 0;
    hit = 0;
    while (1) begin
      m = tree[slot(lvl, idx)];
      if (lvl < tgt && m == bba_pkg::MARK_FREE) begin
        // free node above target: split it and go left only
        tree[slot(lvl, idx)] = bba_pkg::MARK_SPLIT;
        lvl = lvl + 1;
        idx = idx << 1;
      end else if (lvl == tgt && m == bba_pkg::MARK_FREE) begin
        tree[slot(lvl, idx)] = bba_pkg::MARK_USED;
        hit = idx;
        return 1'b1;
      end else if (lvl < tgt && m == bba_pkg::MARK_SPLIT) begin
        up_lvl[sp] = lvl;
        up_idx[sp] = idx;
        sp  = sp + 1;
        lvl = lvl + 1;
        idx = idx << 1;
      end else if (lvl <= tgt && (m == bba_pkg::MARK_USED || m == bba_pkg::MARK_SPLIT) &&
                   lvl != 0 && idx % 2 == 0) begin
        // taken left node: try its buddy
        idx = idx + 1;
      end else if (sp == 0) begin
        return 1'b0;
      end else begin
        // subtree failed: right child of the latest split node
        sp  = sp - 1;
        lvl = up_lvl[sp] + 1;
        idx = (up_idx[sp] << 1) + 1;
      end
    end
  endfunction

  // clear the deepest marked node on the path, then merge free buddies
  function void release_block(int unsigned offset, int unsigned td);
    int unsigned lvl;
    int unsigned idx;
    int unsigned keep_lvl;
    int unsigned keep_idx;
    lvl      = 0;
    idx      = 0;
    keep_lvl = 0;
    keep_idx = 0;
    while (tree[slot(lvl, idx)] != bba_pkg::MARK_FREE) begin
      keep_lvl = lvl;
      keep_idx = idx;
      if (lvl == td) break;
      lvl = lvl + 1;
      idx = offset >> (td - lvl);
    end
    lvl = keep_lvl;
    idx = keep_idx;
    tree[slot(lvl, idx)] = bba_pkg::MARK_FREE;
    while (lvl > 0 && tree[slot(lvl, idx ^ 1)] == bba_pkg::MARK_FREE) begin
      idx = idx >> 1;
      lvl = lvl - 1;
      tree[slot(lvl, idx)] = bba_pkg::MARK_FREE;
    end
  endfunction

  // predict the reply to one accepted request word
  function void note_request(bba_pkg::in_item_t req);
    bba_pkg::out_item_t rsp;
    int unsigned        td;
    int unsigned        hit;
    logic [63:0]        addr64;
    logic [63:0]        base64;
    logic [63:0]        sum;
    rsp    = '0;
    td     = levels();
    addr64 = 64'(req.page_address);
    base64 = 64'(base_page);
    if (req.kind == bba_pkg::KIND_ALLOC) begin
      if (req.block_order > td || !find_block(td - req.block_order, hit)) begin
        rsp.status = bba_pkg::STAT_NO_BLOCK;
        refusals++;
      end else begin
        sum            = base64 + (64'(hit) << req.block_order);
        rsp.status     = bba_pkg::STAT_DONE;
        rsp.block_page = sum[bba_pkg::PAGE_W-1:0] & bba_pkg::PAGE_MASK;
        live_page.push_back(rsp.block_page);
        live_order.push_back(req.block_order);
        grants++;
      end
    end else if (addr64 < base64 || addr64 - base64 >= (64'd1 << td)) begin
      rsp.status = bba_pkg::STAT_OUT_OF_RANGE;
      rejects++;
    end else begin
      release_block(int'(addr64 - base64), td);
      rsp.status = bba_pkg::STAT_DONE;
      releases++;
    end
    due_replies.push_back(rsp);
  endfunction

  // compare one reply word with the oldest prediction
  function void check_reply(bba_pkg::out_item_t got);
    bba_pkg::out_item_t want;
    replies_seen++;
    if (due_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected reply: status %0d page %h", got.status, got.block_page);
      return;
    end
    want = due_replies.pop_front();
    if (got.status !== want.status || got.block_page !== want.block_page) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reply %0d: expected status %0d page %h, got status %0d page %h",
                 replies_seen, want.status, want.block_page, got.status, got.block_page);
    end
  endfunction

  // hand out a granted block for release, if any is left
  function bit take_live(output logic [bba_pkg::PAGE_W-1:0] page,
                         output logic [bba_pkg::ORDER_W-1:0] ord);
    int k;
    page = '0;
    ord  = '0;
    if (live_page.size() == 0) return 1'b0;
    k    = $urandom_range(live_page.size() - 1);
    page = live_page[k];
    ord  = live_order[k];
    live_page.delete(k);
    live_order.delete(k);
    return 1'b1;
  endfunction
endclass

module tb_buddy_block_allocator;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [bba_pkg::PAGE_W-1:0] TOP_PAGE = '1;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  bba_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready;
  bba_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bba_pkg::PAGE_W-1:0]    cfg_data;

  bit calm;
  bit hold_req;
  allocator_shadow shadow;

  always #2 clk = ~clk;

  buddy_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // reply monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_reply(out_data);
  end

  // reply side: random stalls, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // run limit
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [bba_pkg::PAGE_W-1:0] rand_page();
    return bba_pkg::PAGE_W'({$urandom, $urandom});
  endfunction

  // present one request word and wait for it to be taken
  task automatic offer_request(input bba_pkg::in_item_t req);
    int gap;
    if (!calm && $urandom_range(99) < 6) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(req);
    @(negedge clk);
  endtask

  task automatic ask_alloc(input int order);
    bba_pkg::in_item_t req;
    req.kind         = bba_pkg::KIND_ALLOC;
    req.block_order  = bba_pkg::ORDER_W'(order);
    req.page_address = rand_page();
    offer_request(req);
  endtask

  task automatic ask_release(input logic [bba_pkg::PAGE_W-1:0] addr);
    bba_pkg::in_item_t req;
    req.kind         = bba_pkg::KIND_FREE;
    req.block_order  = bba_pkg::ORDER_W'($urandom);
    req.page_address = addr;
    offer_request(req);
  endtask

  // stop offering and wait for every owed reply
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [bba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bba_pkg::PAGE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly allocations and releases of granted blocks, some stray addresses
  function automatic bba_pkg::in_item_t next_request(int unsigned td);
    bba_pkg::in_item_t           req;
    logic [bba_pkg::PAGE_W-1:0]  page;
    logic [bba_pkg::ORDER_W-1:0] ord;
    int unsigned                 pick;
    req.kind         = bba_pkg::KIND_ALLOC;
    req.block_order  = bba_pkg::ORDER_W'($urandom);
    req.page_address = rand_page();
    pick = $urandom_range(99);
    if (pick < 8) begin
      // any order, often above the depth
    end else if (pick < 50) begin
      req.block_order = bba_pkg::ORDER_W'($urandom_range(td));
    end else if (pick < 85) begin
      if (shadow.take_live(page, ord)) begin
        req.kind         = bba_pkg::KIND_FREE;
        req.page_address = page + bba_pkg::PAGE_W'($urandom_range((1 << ord) - 1));
      end else begin
        req.block_order = bba_pkg::ORDER_W'($urandom_range(td));
      end
    end else if (pick < 95) begin
      req.kind         = bba_pkg::KIND_FREE;
      req.page_address = shadow.base_page +
                         bba_pkg::PAGE_W'($urandom_range((1 << td) - 1));
    end else begin
      req.kind = bba_pkg::KIND_FREE;
    end
    return req;
  endfunction

  task automatic run_phase(input logic [bba_pkg::PAGE_W-1:0] base,
                           input logic [bba_pkg::DEPTH_W-1:0] dep,
                           input int count, input bit quiet, input bit squeeze);
    logic [bba_pkg::PAGE_W-1:0] depth_word;
    settle();
    depth_word = rand_page();
    depth_word[bba_pkg::DEPTH_W-1:0] = dep;
    cfg_write(bba_pkg::CFG_REGION_BASE, base);
    cfg_write(bba_pkg::CFG_TREE_DEPTH, depth_word);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      // long reply stall so the block backs up, later a full drain
      if (squeeze && i == 40) hold_req = 1'b1;
      if (squeeze && i == count / 2) settle();
      offer_request(next_request(shadow.levels()));
    end
    calm = 1'b0;
  endtask

  initial begin
    shadow    = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: depth 10, base 0
    ask_release('0);          // release with nothing marked
    ask_alloc(15);            // order above depth
    ask_alloc(10);            // whole region
    ask_alloc(0);             // root already taken
    ask_alloc(10);            // taken root at target level
    ask_release(40'd1023);
    ask_release(40'd1024);    // first page past the region
    ask_alloc(0);
    ask_alloc(0);
    ask_alloc(9);
    ask_alloc(9);             // both halves busy
    ask_release(40'd0);
    ask_release(40'd1);       // merges back up
    ask_release(40'd600);

    // small tree at the top of the page space, grants wrap to zero
    settle();
    cfg_write(bba_pkg::CFG_REGION_BASE, TOP_PAGE - 3);
    cfg_write(bba_pkg::CFG_TREE_DEPTH, 40'd3);
    ask_alloc(0);
    ask_alloc(0);
    ask_release(TOP_PAGE - 1); // frees a split node over taken pages
    ask_alloc(1);
    ask_alloc(1);              // lands past the wrap
    ask_release('0);           // below the base
    ask_alloc(3);
    ask_release(TOP_PAGE);

    // single page region
    settle();
    cfg_write(bba_pkg::CFG_REGION_BASE, 40'h80_0000_0000);
    cfg_write(bba_pkg::CFG_TREE_DEPTH, 40'd0);
    ask_alloc(0);
    ask_alloc(1);
    ask_release(40'h80_0000_0000);

    // random part over several settings
    run_phase(rand_page(), 4'd4, 300, 1'b0, 1'b1);
    run_phase('0, 4'd15, 150, 1'b0, 1'b0);
    run_phase(rand_page(), 4'd6, 300, 1'b1, 1'b0);
    run_phase(TOP_PAGE - 1, 4'd2, 200, 1'b0, 1'b0);
    run_phase(rand_page(), 4'd8, 300, 1'b0, 1'b0);
    run_phase(TOP_PAGE, 4'd1, 100, 1'b0, 1'b0);
    run_phase(rand_page(), 4'd0, 50, 1'b0, 1'b0);
    settle();

    $display("%0d replies: %0d grants, %0d refused allocations, %0d releases, %0d outside region",
             shadow.replies_seen, shadow.grants, shadow.refusals, shadow.releases,
             shadow.rejects);
    $display("depths 0 to 15 and bases up to the top page, with a long reply stall and a drain");
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
